FILE: rtl/core/ktab_pkg.sv
// ----------------------------------------------------------------------------
// ktab_pkg
// Shared codes, field widths and controller/datapath bundles for the keyed
// cpu time accounting table.
// ----------------------------------------------------------------------------
package ktab_pkg;

  // Field widths
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned UID_W   = 32;
  localparam int unsigned PID_W   = 23;
  localparam int unsigned CPU_W   = 8;
  localparam int unsigned NS_W    = 48;
  localparam int unsigned STATE_W = 4;
  localparam int unsigned ROWI_W  = 5;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned USED_W  = 6;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_RECORD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_TRK_ADD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TRK_DEL   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TRK_CLR   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_ROW  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_CPU  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_CLR_ACCT  = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD      = 3'd7;

  // Row kinds
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PROCESS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_APP     = 2'd2;

  // Always-tracked uids
  localparam logic [UID_W-1:0] UID_ROOT   = 32'd0;
  localparam logic [UID_W-1:0] UID_SYSTEM = 32'd1000;

  // ns to ms: (ns + NS_PER_MS/2) / NS_PER_MS, done as a shift by 6, then a
  // reciprocal multiply by floor(2^44 / 15625) that is at most one low,
  // then one compare and subtract to fix the estimate
  localparam int unsigned NS_PER_MS = 1000000;
  localparam int unsigned HALF_MS   = NS_PER_MS / 2;
  localparam int unsigned DIV_SHIFT = 6;
  localparam int unsigned DVD_W     = NS_W + 1 - DIV_SHIFT;
  localparam int unsigned ODD_W     = 14;
  localparam logic [ODD_W-1:0] DIV_ODD = 14'd15625;
  localparam int unsigned RCP_W     = 31;
  localparam logic [RCP_W-1:0] RECIP_M = 31'd1125899906;
  localparam int unsigned RCP_SHIFT = 44;
  localparam int unsigned XL_W      = 22;
  localparam int unsigned XH_W      = DVD_W - XL_W;
  localparam int unsigned QUO_W     = 30;
  localparam int unsigned DCNT_W    = 3;
  localparam int unsigned DIV_STEPS = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic trk_upd;
    logic div_step;
    logic scan_init;
    logic scan_next;
    logic proc;
    logic create;
    logic set_drop;
    logic twr;
    logic cwr;
    logic clr_init;
    logic clr_step;
    logic res_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             div_done;
    logic             scan_end;
    logic             tbl_full;
    logic             hit;
    logic             tracked;
    logic             clr_done;
    logic             out_busy;
  } sts_t;

endpackage

FILE: rtl/core/ktab_ctrl.sv
// ----------------------------------------------------------------------------
// ktab_ctrl
// Sequencer: steps each request through divide, keyed scans, time updates,
// clearing sweeps and result hand-off.
// ----------------------------------------------------------------------------
module ktab_ctrl
  import ktab_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] ST_CLR  = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_EXEC = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_SCAN = 4'd4;
  localparam logic [3:0] ST_META = 4'd5;
  localparam logic [3:0] ST_TRD  = 4'd6;
  localparam logic [3:0] ST_TWR  = 4'd7;
  localparam logic [3:0] ST_CRD  = 4'd8;
  localparam logic [3:0] ST_CWR  = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  logic [3:0] state_q, state_d;
  logic       pass_q, pass_d;
  logic       boot_q, boot_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    boot_d     = boot_q;
    cmd_o      = '0;
    cmd_o.proc = pass_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          boot_d  = 1'b0;
          state_d = boot_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.req)
          REQ_RECORD: state_d = ST_DIV;
          REQ_TRK_ADD, REQ_TRK_DEL, REQ_TRK_CLR: begin
            cmd_o.trk_upd = 1'b1;
            state_d       = ST_DONE;
          end
          REQ_CLR_ACCT: begin
            cmd_o.clr_init = 1'b1;
            state_d        = ST_CLR;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.scan_init = 1'b1;
          pass_d          = 1'b0;
          state_d         = ST_SCAN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_SCAN: begin
        if (!sts_i.scan_end) begin
          state_d = ST_META;
        end else if (!sts_i.tbl_full) begin
          cmd_o.create = 1'b1;
          state_d      = ST_TRD;
        end else begin
          // Table full: drop this place and move on
          cmd_o.set_drop = 1'b1;
          if (!pass_q && sts_i.tracked) begin
            pass_d          = 1'b1;
            cmd_o.scan_init = 1'b1;
            state_d         = ST_SCAN;
          end else begin
            state_d = ST_CRD;
          end
        end
      end
      ST_META: begin
        if (sts_i.hit) begin
          state_d = ST_TRD;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_TRD: state_d = ST_TWR;
      ST_TWR: begin
        cmd_o.twr = 1'b1;
        if (!pass_q && sts_i.tracked) begin
          pass_d          = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end else begin
          state_d = ST_CRD;
        end
      end
      ST_CRD: state_d = ST_CWR;
      ST_CWR: begin
        cmd_o.cwr = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLR;
      pass_q  <= 1'b0;
      boot_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      boot_q  <= boot_d;
    end
  end

endmodule

FILE: rtl/core/ktab_dp.sv
// ----------------------------------------------------------------------------
// ktab_dp
// Datapath: request latch, ns-to-ms divider, row key store, time memories,
// tracked uid slots and the result register.
// ----------------------------------------------------------------------------
module ktab_dp
  import ktab_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT   = 32,
  parameter int unsigned CPU_COUNT     = 8,
  parameter int unsigned STATE_COUNT   = 16,
  parameter int unsigned TRACKED_SLOTS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [UID_W-1:0]    uid_i,
  input  logic [PID_W-1:0]    pid_i,
  input  logic [PID_W-1:0]    tgid_i,
  input  logic [CPU_W-1:0]    cpu_index_i,
  input  logic [NS_W-1:0]     elapsed_ns_i,
  input  logic [STATE_W-1:0]  state_index_i,
  input  logic [ROWI_W-1:0]   row_index_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [NS_W-1:0]     read_time_o,
  output logic [KIND_W-1:0]   row_kind_o,
  output logic [UID_W-1:0]    row_uid_o,
  output logic [PID_W-1:0]    row_pid_o,
  output logic [PID_W-1:0]    row_tgid_o,
  output logic [USED_W-1:0]   rows_used_o,
  output logic                record_dropped_o
);

  localparam int unsigned ROW_W    = $clog2(ENTRY_COUNT);
  localparam int unsigned OCC_W    = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned RT_DEPTH = ENTRY_COUNT * STATE_COUNT;
  localparam int unsigned CT_DEPTH = CPU_COUNT * STATE_COUNT;
  localparam int unsigned RT_W     = (RT_DEPTH > 1) ? $clog2(RT_DEPTH) : 1;
  localparam int unsigned CT_W     = (CT_DEPTH > 1) ? $clog2(CT_DEPTH) : 1;
  localparam int unsigned SWEEP    = (RT_DEPTH > CT_DEPTH) ? RT_DEPTH : CT_DEPTH;
  localparam int unsigned SW_W     = $clog2(SWEEP);

  typedef logic [UID_W-1:0] slot_arr_t [TRACKED_SLOTS];

  // Latched request
  logic [REQ_W-1:0]   req_q;
  logic [UID_W-1:0]   uid_q;
  logic [PID_W-1:0]   pid_q, tgid_q;
  logic [CPU_W-1:0]   cpu_q;
  logic [STATE_W-1:0] state_q;
  logic [ROWI_W-1:0]  row_q;

  // Divider
  logic [DVD_W-1:0]       dvd_q;
  logic [DCNT_W-1:0]      dcnt_q;
  logic [NS_W:0]          ns_sum;
  logic [XL_W+RCP_W-1:0]  plo_q;
  logic [XH_W+RCP_W-1:0]  phi_q;
  logic [DVD_W+RCP_W-1:0] psum;
  logic [QUO_W-1:0]       quo_q;
  logic [QUO_W+ODD_W-1:0] qd_q;
  logic [DVD_W-1:0]       rem_est;
  logic [NS_W-1:0]        ms;

  // Control counters
  logic [OCC_W-1:0]  occ_q, idx_q;
  logic [SW_W-1:0]   clr_cnt_q;
  logic              drop_q;
  logic [UID_W-1:0]  trk_q [TRACKED_SLOTS];

  // Memories and their read registers
  logic [KIND_W-1:0] kind_mem [ENTRY_COUNT];
  logic [UID_W-1:0]  uid_mem  [ENTRY_COUNT];
  logic [PID_W-1:0]  pid_mem  [ENTRY_COUNT];
  logic [PID_W-1:0]  tgid_mem [ENTRY_COUNT];
  logic [NS_W-1:0]   rt_mem   [RT_DEPTH];
  logic [NS_W-1:0]   ct_mem   [CT_DEPTH];
  logic [KIND_W-1:0] kind_rd_q;
  logic [UID_W-1:0]  uid_rd_q;
  logic [PID_W-1:0]  pid_rd_q, tgid_rd_q;
  logic [NS_W-1:0]   trd_q, crd_q;

  logic [ROW_W+ROWI_W-1:0] row_ext;
  logic [ROW_W-1:0]        row_rd;
  logic [31:0]             rt_full, ct_full;
  logic [RT_W-1:0]         rt_addr, rt_waddr;
  logic [CT_W-1:0]         ct_addr, ct_waddr;
  logic                    rt_we, ct_we;
  logic [NS_W-1:0]         rt_wdata, ct_wdata;
  logic                    state_ok, cpu_ok, row_ok, tracked, hit;
  logic [KIND_W-1:0]       cur_kind;
  logic [OCC_W+USED_W-1:0] occ_ext;

  // Output register
  logic              out_valid_q;
  logic [NS_W-1:0]   res_time_q;
  logic [KIND_W-1:0] res_kind_q;
  logic [UID_W-1:0]  res_uid_q;
  logic [PID_W-1:0]  res_pid_q, res_tgid_q;
  logic [USED_W-1:0] res_used_q;
  logic              res_drop_q;

  // Add stops at the first empty or equal slot; remove empties the first equal
  function automatic logic [TRACKED_SLOTS-1:0][UID_W-1:0] trk_pack(
    input logic [UID_W-1:0] t [TRACKED_SLOTS]);
    logic [TRACKED_SLOTS-1:0][UID_W-1:0] p;
    for (int i = 0; i < int'(TRACKED_SLOTS); i++) p[i] = t[i];
    return p;
  endfunction

  function automatic slot_arr_t trk_next(input logic [UID_W-1:0] t [TRACKED_SLOTS],
                                         input logic [UID_W-1:0] u, input logic add);
    slot_arr_t n;
    logic      found;
    logic [TRACKED_SLOTS-1:0][UID_W-1:0] p;
    p     = trk_pack(t);
    found = 1'b0;
    for (int i = 0; i < int'(TRACKED_SLOTS); i++) begin
      n[i] = p[i];
      if (!found) begin
        if (add && (p[i] == '0 || p[i] == u)) begin
          found = 1'b1;
          n[i]  = u;
        end else if (!add && p[i] == u) begin
          found = 1'b1;
          n[i]  = '0;
        end
      end
    end
    return n;
  endfunction

  // Range checks and addressing
  assign state_ok = 32'(state_q) < 32'(STATE_COUNT);
  assign cpu_ok   = 32'(cpu_q) < 32'(CPU_COUNT);
  assign row_ext  = (ROW_W+ROWI_W)'(row_q);
  assign row_ok   = (32'(row_q) < 32'(ENTRY_COUNT)) && (32'(row_q) < 32'(occ_q));
  assign row_rd   = (req_q == REQ_READ_ROW) ? row_ext[ROW_W-1:0] : idx_q[ROW_W-1:0];
  assign rt_full  = 32'(row_rd) * 32'(STATE_COUNT) + 32'(state_q);
  assign ct_full  = 32'(cpu_q) * 32'(STATE_COUNT) + 32'(state_q);
  assign rt_addr  = rt_full[RT_W-1:0];
  assign ct_addr  = ct_full[CT_W-1:0];
  assign occ_ext  = (OCC_W+USED_W)'(occ_q);

  // Divider partial sums and ms value
  assign ns_sum  = {1'b0, elapsed_ns_i} + (NS_W+1)'(HALF_MS);
  assign psum    = {phi_q, {XL_W{1'b0}}} + (DVD_W+RCP_W)'(plo_q);
  assign rem_est = dvd_q - qd_q[DVD_W-1:0];
  assign ms      = NS_W'(quo_q);

  // Tracked uid lookup and key compare
  always_comb begin
    tracked = (uid_q == UID_ROOT) || (uid_q == UID_SYSTEM);
    for (int i = 0; i < int'(TRACKED_SLOTS); i++) begin
      if (trk_q[i] == uid_q) tracked = 1'b1;
    end
  end
  assign cur_kind = cmd_i.proc ? KIND_PROCESS : KIND_APP;
  assign hit = (kind_rd_q == cur_kind) &&
               (cmd_i.proc ? (pid_rd_q == pid_q) : (uid_rd_q == uid_q));

  // Status to the controller
  always_comb begin
    sts_o.req      = req_q;
    sts_o.div_done = dcnt_q == DCNT_W'(DIV_STEPS);
    sts_o.scan_end = idx_q == occ_q;
    sts_o.tbl_full = occ_q == OCC_W'(ENTRY_COUNT);
    sts_o.hit      = hit;
    sts_o.tracked  = tracked;
    sts_o.clr_done = clr_cnt_q == SW_W'(SWEEP - 1);
    sts_o.out_busy = out_valid_q && !out_ready_i;
  end

  // Latch request and run the divider: split multiply, sum, back-multiply, fix
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= req_type_i;
      uid_q   <= uid_i;
      pid_q   <= pid_i;
      tgid_q  <= tgid_i;
      cpu_q   <= cpu_index_i;
      state_q <= state_index_i;
      row_q   <= row_index_i;
      dvd_q   <= ns_sum[NS_W:DIV_SHIFT];
    end else if (cmd_i.div_step) begin
      if (dcnt_q == DCNT_W'(0)) begin
        plo_q <= {{RCP_W{1'b0}}, dvd_q[XL_W-1:0]} * {{XL_W{1'b0}}, RECIP_M};
        phi_q <= {{RCP_W{1'b0}}, dvd_q[DVD_W-1:XL_W]} * {{XH_W{1'b0}}, RECIP_M};
      end else if (dcnt_q == DCNT_W'(1)) begin
        quo_q <= psum[RCP_SHIFT +: QUO_W];
      end else if (dcnt_q == DCNT_W'(2)) begin
        qd_q <= {{ODD_W{1'b0}}, quo_q} * {{QUO_W{1'b0}}, DIV_ODD};
      end else if (rem_est >= DVD_W'(DIV_ODD)) begin
        quo_q <= quo_q + QUO_W'(1);
      end
    end
  end

  // Control counters, drop flag, tracked slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q    <= '0;
      idx_q     <= '0;
      occ_q     <= '0;
      clr_cnt_q <= '0;
      drop_q    <= 1'b0;
      for (int i = 0; i < int'(TRACKED_SLOTS); i++) trk_q[i] <= '0;
    end else begin
      if (cmd_i.load) begin
        dcnt_q <= '0;
        drop_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
      end
      if (cmd_i.scan_init) begin
        idx_q <= '0;
      end else if (cmd_i.scan_next) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.set_drop) drop_q <= 1'b1;
      // Clear empties the table by resetting the fill count
      if (cmd_i.clr_init) begin
        occ_q     <= '0;
        clr_cnt_q <= '0;
      end else begin
        if (cmd_i.create) occ_q <= occ_q + 1'b1;
        if (cmd_i.clr_step) clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.trk_upd) begin
        if (req_q == REQ_TRK_CLR) begin
          for (int i = 0; i < int'(TRACKED_SLOTS); i++) trk_q[i] <= '0;
        end else begin
          trk_q <= trk_next(trk_q, uid_q, req_q == REQ_TRK_ADD);
        end
      end
    end
  end

  // Row key store: written on create, read at the scan or requested row
  always_ff @(posedge clk_i) begin
    if (cmd_i.create) begin
      kind_mem[idx_q[ROW_W-1:0]] <= cur_kind;
      uid_mem[idx_q[ROW_W-1:0]]  <= uid_q;
      pid_mem[idx_q[ROW_W-1:0]]  <= cmd_i.proc ? pid_q : '0;
      tgid_mem[idx_q[ROW_W-1:0]] <= cmd_i.proc ? tgid_q : '0;
    end
    kind_rd_q <= kind_mem[row_rd];
    uid_rd_q  <= uid_mem[row_rd];
    pid_rd_q  <= pid_mem[row_rd];
    tgid_rd_q <= tgid_mem[row_rd];
  end

  // Time memory write ports: sweep zeros or add ms
  always_comb begin
    rt_we    = 1'b0;
    rt_waddr = rt_addr;
    rt_wdata = trd_q + ms;
    ct_we    = 1'b0;
    ct_waddr = ct_addr;
    ct_wdata = crd_q + ms;
    if (cmd_i.clr_step) begin
      rt_we    = 32'(clr_cnt_q) < 32'(RT_DEPTH);
      rt_waddr = clr_cnt_q[RT_W-1:0];
      rt_wdata = '0;
      ct_we    = 32'(clr_cnt_q) < 32'(CT_DEPTH);
      ct_waddr = clr_cnt_q[CT_W-1:0];
      ct_wdata = '0;
    end else begin
      rt_we = cmd_i.twr && state_ok;
      ct_we = cmd_i.cwr && state_ok && cpu_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rt_we) rt_mem[rt_waddr] <= rt_wdata;
    trd_q <= rt_mem[rt_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ct_we) ct_mem[ct_waddr] <= ct_wdata;
    crd_q <= ct_mem[ct_addr];
  end

  // Result register: hold until the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_time_q <= '0;
      res_kind_q <= KIND_EMPTY;
      res_uid_q  <= '0;
      res_pid_q  <= '0;
      res_tgid_q <= '0;
      res_used_q <= occ_ext[USED_W-1:0];
      res_drop_q <= drop_q;
      if (req_q == REQ_READ_ROW && row_ok) begin
        res_time_q <= state_ok ? trd_q : '0;
        res_kind_q <= kind_rd_q;
        res_uid_q  <= uid_rd_q;
        res_pid_q  <= pid_rd_q;
        res_tgid_q <= tgid_rd_q;
      end else if (req_q == REQ_READ_CPU && cpu_ok && state_ok) begin
        res_time_q <= crd_q;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_time_o      = res_time_q;
  assign row_kind_o       = res_kind_q;
  assign row_uid_o        = res_uid_q;
  assign row_pid_o        = res_pid_q;
  assign row_tgid_o       = res_tgid_q;
  assign rows_used_o      = res_used_q;
  assign record_dropped_o = res_drop_q;

endmodule

FILE: rtl/core/keyed_cpu_time_accounting_table.sv
// ----------------------------------------------------------------------------
// keyed_cpu_time_accounting_table
// Accumulates per-app, per-process and per-cpu time by frequency state.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A record is accepted, decoded and its ns
// converted to ms (a reciprocal multiply in four steps plus a done check);
// each row compared in a keyed scan takes a scan and a meta state (one scan
// for the app row, a second for the process row of a tracked uid), a scan
// that misses creates the row, each time update reads then writes its memory
// and a final hand-off waits for a free output; scans walk the single-port
// row key store one row at a time. Reads and tracked-set edits go from decode
// straight to hand-off. After reset, and for every clear-accounting request,
// a sweep over max(ENTRY_COUNT*STATE_COUNT, CPU_COUNT*STATE_COUNT) addresses
// zeroes the time memories; no beat is taken during the sweep. A finished
// result waits in an output register while the next beat is accepted.
module keyed_cpu_time_accounting_table
  import ktab_pkg::*;
#(
  parameter int unsigned ENTRY_COUNT   = 32,
  parameter int unsigned CPU_COUNT     = 8,
  parameter int unsigned STATE_COUNT   = 16,
  parameter int unsigned TRACKED_SLOTS = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // uid, pid, tgid, cpu_index, elapsed_ns, state_index, row_index, pad
  input  logic [143:0] s_axis_tdata_i,
  // req_type
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // read_time, row_kind, row_uid, row_pid, row_tgid, rows_used,
  // record_dropped, pad
  output logic [135:0] m_axis_tdata_o
);

  cmd_t cmd;
  sts_t sts;

  logic [NS_W-1:0]   read_time;
  logic [KIND_W-1:0] row_kind;
  logic [UID_W-1:0]  row_uid;
  logic [PID_W-1:0]  row_pid, row_tgid;
  logic [USED_W-1:0] rows_used;
  logic              record_dropped;

  ktab_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ktab_dp #(
    .ENTRY_COUNT   (ENTRY_COUNT),
    .CPU_COUNT     (CPU_COUNT),
    .STATE_COUNT   (STATE_COUNT),
    .TRACKED_SLOTS (TRACKED_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_type_i       (s_axis_tuser_i),
    .uid_i            (s_axis_tdata_i[31:0]),
    .pid_i            (s_axis_tdata_i[54:32]),
    .tgid_i           (s_axis_tdata_i[77:55]),
    .cpu_index_i      (s_axis_tdata_i[85:78]),
    .elapsed_ns_i     (s_axis_tdata_i[133:86]),
    .state_index_i    (s_axis_tdata_i[137:134]),
    .row_index_i      (s_axis_tdata_i[142:138]),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .read_time_o      (read_time),
    .row_kind_o       (row_kind),
    .row_uid_o        (row_uid),
    .row_pid_o        (row_pid),
    .row_tgid_o       (row_tgid),
    .rows_used_o      (rows_used),
    .record_dropped_o (record_dropped)
  );

  // Pack the result beat
  assign m_axis_tdata_o = {1'b0, record_dropped, rows_used, row_tgid, row_pid,
                           row_uid, row_kind, read_time};

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams requests into the keyed cpu time accounting table and compares each
// result beat with a behavioral model of the app, process and cpu rows.
// ----------------------------------------------------------------------------
module tb;
  import ktab_pkg::*;

  localparam int unsigned ROWS   = 32;
  localparam int unsigned CPUS   = 8;
  localparam int unsigned STATES = 16;
  localparam int unsigned SLOTS  = 10;
  localparam int unsigned IDLE_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  req;
    logic [31:0] uid;
    logic [22:0] pid;
    logic [22:0] tgid;
    logic [7:0]  cpu;
    logic [47:0] ns;
    logic [3:0]  state;
    logic [4:0]  row;
  } acct_req_t;

  // Lowest field last so the layout matches the result beat
  typedef struct packed {
    logic        dropped;
    logic [5:0]  used;
    logic [22:0] tgid;
    logic [22:0] pid;
    logic [31:0] uid;
    logic [1:0]  kind;
    logic [47:0] rtime;
  } acct_rsp_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [143:0] s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [135:0] m_axis_tdata_o;

  keyed_cpu_time_accounting_table dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state
  logic [1:0]  tab_kind [ROWS];
  logic [31:0] tab_uid  [ROWS];
  logic [22:0] tab_pid  [ROWS];
  logic [22:0] tab_tgid [ROWS];
  logic [47:0] tab_time [ROWS*STATES];
  logic [47:0] cpu_time [CPUS*STATES];
  int unsigned tab_used;
  logic [31:0] trk_uid  [SLOTS];

  acct_req_t pending_reqs[$];
  acct_rsp_t expected_rsps[$];
  bit        failed = 1'b0;
  bit        stim_done = 1'b0;
  int        idle_cycles = 0;
  int        gap_in = 0;
  int        gap_out = 0;

  function automatic void clear_accounting();
    for (int i = 0; i < ROWS; i++) begin
      tab_kind[i] = KIND_EMPTY; tab_uid[i] = '0; tab_pid[i] = '0; tab_tgid[i] = '0;
    end
    foreach (tab_time[i]) tab_time[i] = '0;
    foreach (cpu_time[i]) cpu_time[i] = '0;
    tab_used = 0;
  endfunction

  function automatic bit uid_tracked(logic [31:0] uid);
    if (uid == UID_ROOT || uid == UID_SYSTEM) return 1'b1;
    for (int i = 0; i < SLOTS; i++) if (trk_uid[i] == uid) return 1'b1;
    return 1'b0;
  endfunction

  // Find or create the keyed row and add time; return 1 when the table is full
  function automatic bit add_row_time(logic [1:0] kind, acct_req_t r, logic [47:0] ms);
    int i;
    for (i = 0; i < tab_used; i++) begin
      if (tab_kind[i] == kind &&
          ((kind == KIND_PROCESS) ? (tab_pid[i] == r.pid) : (tab_uid[i] == r.uid)))
        break;
    end
    if (i == tab_used) begin
      if (tab_used >= ROWS) return 1'b1;
      tab_kind[i] = kind;
      tab_uid[i]  = r.uid;
      tab_pid[i]  = (kind == KIND_PROCESS) ? r.pid : '0;
      tab_tgid[i] = (kind == KIND_PROCESS) ? r.tgid : '0;
      tab_used++;
    end
    if (r.state < STATES) tab_time[i*STATES + r.state] += ms;
    return 1'b0;
  endfunction

  function automatic acct_rsp_t account_request(acct_req_t r);
    acct_rsp_t   o;
    logic [48:0] ms;
    o = '0;
    case (r.req)
      REQ_RECORD: begin
        ms = ({1'b0, r.ns} + 49'd500000) / 49'd1000000;
        if (add_row_time(KIND_APP, r, ms[47:0])) o.dropped = 1'b1;
        if (uid_tracked(r.uid) && add_row_time(KIND_PROCESS, r, ms[47:0]))
          o.dropped = 1'b1;
        if (r.cpu < CPUS) cpu_time[r.cpu*STATES + r.state] += ms[47:0];
      end
      REQ_TRK_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (trk_uid[i] == 0) begin
            trk_uid[i] = r.uid;
            break;
          end
          if (trk_uid[i] == r.uid) break;
        end
      end
      REQ_TRK_DEL: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (trk_uid[i] == r.uid) begin
            trk_uid[i] = '0;
            break;
          end
        end
      end
      REQ_TRK_CLR: foreach (trk_uid[i]) trk_uid[i] = '0;
      REQ_READ_ROW: begin
        o.kind = tab_kind[r.row]; o.uid = tab_uid[r.row];
        o.pid = tab_pid[r.row]; o.tgid = tab_tgid[r.row];
        o.rtime = tab_time[r.row*STATES + r.state];
      end
      REQ_READ_CPU: if (r.cpu < CPUS) o.rtime = cpu_time[r.cpu*STATES + r.state];
      REQ_CLR_ACCT: clear_accounting();
      default: ;
    endcase
    o.used = tab_used[5:0];
    return o;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic acct_req_t rand_req(logic [2:0] req);
    acct_req_t r;
    logic [31:0] uids[6];
    uids = '{32'd0, 32'd1000, 32'd10001, 32'd10002, 32'd10003, 32'hFFFF_FFFF};
    r.req   = req;
    r.uid   = ($urandom_range(0, 9) < 8) ? uids[$urandom_range(0, 5)] : $urandom;
    r.pid   = ($urandom_range(0, 3) == 0) ? 23'($urandom) : 23'($urandom_range(1, 12));
    r.tgid  = 23'($urandom);
    r.cpu   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
    r.ns    = ($urandom_range(0, 9) == 0) ? {16'($urandom), 32'($urandom)}
                                          : 48'($urandom_range(0, 30000000));
    r.state = 4'($urandom);
    r.row   = 5'($urandom);
    return r;
  endfunction

  // Fill the request queue: directed cases first, then weighted random
  initial begin
    acct_req_t r;
    int p;
    r = rand_req(REQ_RECORD);
    r.uid = 32'd1000; r.pid = 23'h7F_FFFF; r.tgid = 23'h7F_FFFF; r.cpu = 8'd7;
    r.ns = 48'd499999; r.state = 4'd15; pending_reqs.push_back(r);
    r.uid = 32'hFFFF_FFFF; r.ns = 48'd500000; r.cpu = 8'd0; r.state = 4'd0;
    pending_reqs.push_back(r);
    r.uid = 32'd0; r.pid = 23'd0; r.tgid = 23'd0; r.ns = 48'hFFFF_FFFF_FFFF;
    r.cpu = 8'd255; pending_reqs.push_back(r);
    r.req = REQ_TRK_ADD; r.uid = 32'd12345; pending_reqs.push_back(r);
    r.req = REQ_RECORD; r.pid = 23'd77; r.ns = 48'd1500000; pending_reqs.push_back(r);
    r.req = REQ_TRK_DEL; pending_reqs.push_back(r);
    r.req = REQ_RSVD; pending_reqs.push_back(r);
    for (int i = 0; i < 4; i++) begin
      r.req = REQ_READ_ROW; r.row = 5'(i); r.state = 4'(i*5); pending_reqs.push_back(r);
    end
    r.req = REQ_READ_ROW; r.row = 5'd31; pending_reqs.push_back(r);
    r.req = REQ_READ_CPU; r.cpu = 8'd0; r.state = 4'd0; pending_reqs.push_back(r);
    r.cpu = 8'd7; r.state = 4'd15; pending_reqs.push_back(r);
    r.cpu = 8'd8; pending_reqs.push_back(r);
    r.req = REQ_TRK_CLR; pending_reqs.push_back(r);
    // Overfill the table with distinct app uids to reach the full case
    for (int i = 0; i < 34; i++) begin
      r = rand_req(REQ_RECORD); r.uid = 32'd50000 + i; pending_reqs.push_back(r);
    end
    r.req = REQ_CLR_ACCT; pending_reqs.push_back(r);
    for (int n = 0; n < 900; n++) begin
      p = $urandom_range(0, 99);
      if (p < 50)      r = rand_req(REQ_RECORD);
      else if (p < 58) r = rand_req(REQ_TRK_ADD);
      else if (p < 63) r = rand_req(REQ_TRK_DEL);
      else if (p < 65) r = rand_req(REQ_TRK_CLR);
      else if (p < 85) r = rand_req(REQ_READ_ROW);
      else if (p < 97) r = rand_req(REQ_READ_CPU);
      else if (p < 98) r = rand_req(REQ_RSVD);
      else             r = rand_req(REQ_CLR_ACCT);
      pending_reqs.push_back(r);
    end
  end

  // Drive request beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        void'(pending_reqs.pop_front());
        gap_in <= pick_gap();
      end
      if (!(s_axis_tvalid_i && !s_axis_tready_o)) begin
        if (pending_reqs.size() > 0 && gap_in == 0 &&
            !(s_axis_tvalid_i && s_axis_tready_o && 0)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= pending_reqs[0].req;
          s_axis_tdata_i  <= {1'b0, pending_reqs[0].row, pending_reqs[0].state,
                              pending_reqs[0].ns, pending_reqs[0].cpu,
                              pending_reqs[0].tgid, pending_reqs[0].pid,
                              pending_reqs[0].uid};
        end else begin
          s_axis_tvalid_i <= 1'b0;
          if (gap_in > 0 && !(s_axis_tvalid_i && s_axis_tready_o)) gap_in <= gap_in - 1;
        end
      end
      if (pending_reqs.size() == 0) stim_done <= 1'b1;
    end
  end

  // Predict on accepted request beats; check result beats
  always @(posedge clk_i) begin
    acct_req_t r;
    acct_rsp_t got;
    acct_rsp_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        r.req = s_axis_tuser_i;
        {r.row, r.state, r.ns, r.cpu, r.tgid, r.pid, r.uid} = s_axis_tdata_i[142:0];
        expected_rsps.push_back(account_request(r));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[134:0];
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, got);
          failed = 1'b1;
        end else begin
          want = expected_rsps.pop_front();
          if (got !== want) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, got);
            failed = 1'b1;
          end
        end
      end
      // Stall the result side at random
      if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap_out <= pick_gap();
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_accounting();
    foreach (trk_uid[i]) trk_uid[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!(stim_done && expected_rsps.size() == 0) && idle_cycles < IDLE_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
    end else begin
      repeat (200) @(posedge clk_i);
      if (!failed) begin
        $display("simulation ok");
      end else begin
        $display("simulation failed");
      end
    end
    $finish;
  end

endmodule
